// File: src/brid_pkg.sv
// shared types, codes and helpers for the bitmap record id allocator
// no dependencies
`default_nettype none

package brid_pkg;

    // default geometry of the id space
    localparam int PAGE_RECORDS_DEF = 1024;
    localparam int PAGE_COUNT_DEF   = 4;

    // bitmap word geometry
    localparam int WORD_BITS = 32;
    localparam int BIT_IDX_W = 5;
    localparam logic [WORD_BITS-1:0] FULL_WORD = 32'hffff_ffff;

    // item field widths
    localparam int REC_ID_W = 12;
    localparam int STATUS_W = 2;

    // operation codes
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_FREE = 2'd2;

    // controller states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MODIFY
    } brid_state_t;

    // index of the lowest clear bit of a word, zero when the word is full
    function automatic logic [BIT_IDX_W-1:0] first_zero(input logic [WORD_BITS-1:0] word);
        logic [BIT_IDX_W-1:0] idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (!word[i])
            begin
                idx = BIT_IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

// File: src/brid_bitmap_ram.sv
// synchronous bitmap word memory, one write and one registered read port
// depends on brid_pkg for the word width
`default_nettype none

module brid_bitmap_ram
    import brid_pkg::*;
#(
    parameter int DEPTH = 128,
    parameter int AW    = 7
)
(
    input  wire logic                 clk,
    input  wire logic                 wr_en,
    input  wire logic [AW-1:0]        wr_addr,
    input  wire logic [WORD_BITS-1:0] wr_data,
    input  wire logic                 rd_en,
    input  wire logic [AW-1:0]        rd_addr,
    output logic      [WORD_BITS-1:0] rd_data
);

    logic [WORD_BITS-1:0] bitmap_mem [DEPTH];
    logic [WORD_BITS-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            bitmap_mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= bitmap_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: src/brid_first_free.sv
// priority encoder that picks the lowest word whose full flag is clear
// depends on brid_pkg
`default_nettype none

module brid_first_free
    import brid_pkg::*;
#(
    parameter int NUM_WORDS = 128,
    parameter int AW        = 7
)
(
    input  wire logic [NUM_WORDS-1:0] full_flags,
    output logic                      found,
    output logic      [AW-1:0]        index
);

    // scan from the top so the lowest open word wins
    always_comb
    begin
        found = 1'b0;
        index = '0;
        for (int i = NUM_WORDS - 1; i >= 0; i--)
        begin
            if (!full_flags[i])
            begin
                found = 1'b1;
                index = AW'(i);
            end
        end
    end

endmodule

`default_nettype wire

// File: src/bitmap_record_id_allocator.sv
// An accepted item reads its bitmap word; the modify state checks and rewrites it, and done
// is registered from that state. busy is high in the modify state, so a new item waits for
// idle. An allocation picks its word with the full-flag priority encoder, a free takes it
// from the record id. The receiver cannot stall: each result shows for one cycle.
// Reset: a clearing pass over all TOTAL_WORDS words (128 by default) writes the bitmap with
// only record 0 set; busy is high during that pass.
`default_nettype none

module bitmap_record_id_allocator
    import brid_pkg::*;
#(
    parameter int PAGE_RECORDS = PAGE_RECORDS_DEF,
    parameter int PAGE_COUNT   = PAGE_COUNT_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic                func,
    input  wire logic [REC_ID_W-1:0] record_id,
    output logic                     busy,
    output logic                     done,
    output logic      [STATUS_W-1:0] status,
    output logic      [REC_ID_W-1:0] granted_id,
    output logic                     word_emptied
);

    localparam int TOTAL_IDS   = PAGE_RECORDS * PAGE_COUNT;
    localparam int TOTAL_WORDS = (TOTAL_IDS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW          = (TOTAL_WORDS > 1) ? $clog2(TOTAL_WORDS) : 1;
    localparam logic [AW-1:0] LAST_WORD = AW'(TOTAL_WORDS - 1);
    localparam logic [31:0]   TOTAL_IDS_V = 32'(TOTAL_IDS);

    brid_state_t state_reg, state_next;

    logic [AW-1:0]          clr_addr_reg, clr_addr_next;
    logic                   func_reg;
    logic                   miss_reg;
    logic [AW-1:0]          word_reg;
    logic [BIT_IDX_W-1:0]   bit_reg;
    logic [TOTAL_WORDS-1:0] full_flags_reg;
    logic                   done_reg;
    logic [STATUS_W-1:0]    status_reg;
    logic [REC_ID_W-1:0]    granted_reg;
    logic                   emptied_reg;

    logic                   accept;
    logic                   enc_found;
    logic [AW-1:0]          enc_index;
    logic [31:0]            id_ext;
    logic                   free_bad;
    logic [AW-1:0]          free_word;

    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic [WORD_BITS-1:0]   rd_data;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [WORD_BITS-1:0]   wr_data;
    logic                   flag_wr;
    logic                   flag_val;

    logic [BIT_IDX_W-1:0]   alloc_bit;
    logic [31:0]            alloc_id;
    logic [WORD_BITS-1:0]   free_mask;
    logic [WORD_BITS-1:0]   alloc_mask;
    logic [WORD_BITS-1:0]   freed_word;
    logic [WORD_BITS-1:0]   taken_word;

    logic                   res_valid;
    logic [STATUS_W-1:0]    res_status;
    logic [REC_ID_W-1:0]    res_granted;
    logic                   res_emptied;

    // lowest open word
    brid_first_free #(
        .NUM_WORDS (TOTAL_WORDS),
        .AW        (AW)
    ) u_first_free (
        .full_flags (full_flags_reg),
        .found      (enc_found),
        .index      (enc_index)
    );

    // bitmap storage
    brid_bitmap_ram #(
        .DEPTH (TOTAL_WORDS),
        .AW    (AW)
    ) u_bitmap_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // decode of the incoming item
    assign accept    = start && (state_reg == ST_IDLE);
    assign id_ext    = 32'(record_id);
    assign free_bad  = (record_id == '0) || (id_ext >= TOTAL_IDS_V);
    assign free_word = id_ext[BIT_IDX_W +: AW];

    // word update candidates
    assign alloc_bit  = first_zero(rd_data);
    assign alloc_id   = 32'({word_reg, alloc_bit});
    assign alloc_mask = WORD_BITS'(1) << alloc_bit;
    assign free_mask  = WORD_BITS'(1) << bit_reg;
    assign taken_word = rd_data | alloc_mask;
    assign freed_word = rd_data & ~free_mask;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == LAST_WORD)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_MODIFY;
                end
            end
            ST_MODIFY:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // outputs and memory controls per state
    always_comb
    begin
        busy          = 1'b1;
        clr_addr_next = clr_addr_reg;
        rd_en         = 1'b0;
        rd_addr       = enc_index;
        wr_en         = 1'b0;
        wr_addr       = word_reg;
        wr_data       = freed_word;
        flag_wr       = 1'b0;
        flag_val      = 1'b0;
        res_valid     = 1'b0;
        res_status    = STATUS_OK;
        res_granted   = '0;
        res_emptied   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                wr_en         = 1'b1;
                wr_addr       = clr_addr_reg;
                wr_data       = (clr_addr_reg == '0) ? WORD_BITS'(1) : '0;
                clr_addr_next = clr_addr_reg + AW'(1);
            end
            ST_IDLE:
            begin
                busy    = 1'b0;
                rd_en   = start;
                rd_addr = (func == FUNC_FREE) ? free_word : enc_index;
            end
            ST_MODIFY:
            begin
                res_valid = 1'b1;
                if (func_reg == FUNC_ALLOC)
                begin
                    // the tail of a partial last word is never handed out
                    if (miss_reg || (alloc_id >= TOTAL_IDS_V))
                    begin
                        res_status = STATUS_FULL;
                    end
                    else
                    begin
                        wr_en       = 1'b1;
                        wr_data     = taken_word;
                        flag_wr     = 1'b1;
                        flag_val    = (taken_word == FULL_WORD);
                        res_granted = alloc_id[REC_ID_W-1:0];
                    end
                end
                else
                begin
                    if (miss_reg || ((rd_data & free_mask) == '0))
                    begin
                        res_status = STATUS_BAD_FREE;
                    end
                    else
                    begin
                        wr_en       = 1'b1;
                        wr_data     = freed_word;
                        flag_wr     = 1'b1;
                        flag_val    = 1'b0;
                        res_emptied = (freed_word == '0);
                    end
                end
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            full_flags_reg <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            done_reg     <= res_valid;
            if (flag_wr)
            begin
                full_flags_reg[word_reg] <= flag_val;
            end
        end
    end

    // item and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= func;
            bit_reg  <= record_id[BIT_IDX_W-1:0];
            if (func == FUNC_FREE)
            begin
                miss_reg <= free_bad;
                word_reg <= free_word;
            end
            else
            begin
                miss_reg <= !enc_found;
                word_reg <= enc_index;
            end
        end
        if (res_valid)
        begin
            status_reg  <= res_status;
            granted_reg <= res_granted;
            emptied_reg <= res_emptied;
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign granted_id   = granted_reg;
    assign word_emptied = emptied_reg;

`ifndef SYNTHESIS
    // an accepted item always gets its result strobe
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("accepted item produced no result strobe");

    // a strobe only follows the modify step
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_MODIFY))
        else $error("result strobe without a modify step");

    // no undefined status code leaves the block
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status != 2'd3))
        else $error("undefined status code");

    // a granted id only comes with an ok status
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (granted_id != '0)) |-> (status == STATUS_OK))
        else $error("granted id on a failed item");

    // an emptied word only comes from a successful free
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && word_emptied) |-> ((status == STATUS_OK) && (granted_id == '0)))
        else $error("word emptied flag on a non-free result");
`endif

endmodule

`default_nettype wire
